### rtl/core/bwt_pkg.sv
package bwt_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned WAIT_W   = 5;
    localparam int unsigned COST_W   = 6;
    localparam int unsigned REGION_W = 4;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [7:0] PAGE_LAST_ONCHIP = 8'h07;
    localparam logic [7:0] PAGE_ROM_FIRST   = 8'h08;
    localparam logic [7:0] PAGE_ROM_LAST    = 8'h0D;
    localparam logic [7:0] PAGE_BACKUP      = 8'h0E;

    typedef enum logic [REGION_W-1:0] {
        REG_BIOS      = 4'd0,
        REG_UNUSED    = 4'd1,
        REG_SLOW_WRAM = 4'd2,
        REG_FAST_WRAM = 4'd3,
        REG_IO        = 4'd4,
        REG_PALETTE   = 4'd5,
        REG_VRAM      = 4'd6,
        REG_OAM       = 4'd7,
        REG_ROM0      = 4'd8,
        REG_ROM1      = 4'd9,
        REG_ROM2      = 4'd10,
        REG_BACKUP    = 4'd11,
        REG_INVALID   = 4'd12
    } region_t;

    typedef enum logic [1:0] {
        WIDTH_BYTE = 2'd0,
        WIDTH_HALF = 2'd1,
        WIDTH_WORD = 2'd2,
        WIDTH_NONE = 2'd3
    } access_width_t;

    localparam logic [1:0] KIND_NONSEQ = 2'd0;
    localparam logic [1:0] KIND_SEQ    = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM0_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM0_NEXT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM1_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM1_NEXT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM2_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM2_NEXT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYPAD     = 3'd6;

    localparam logic [ADDR_W-1:0] KEYPAD_RESET = 32'h0400_0130;

    // one nonsequential/sequential pair per ROM window
    typedef struct packed {
        logic [2:0][WAIT_W-1:0] first;
        logic [2:0][WAIT_W-1:0] next;
    } rom_wait_t;

    typedef struct packed {
        logic [ADDR_W-1:0] bus_address;
        logic [1:0]        access_width;
        logic [1:0]        access_kind;
        logic              is_read;
    } access_t;

endpackage

### rtl/core/bus_access_waitstate_timer.sv
// Bus access wait-state timer. Each item on the slave side is one bus access;
// for each the block returns one item with the region decoded from address
// bits 31..24, the wait cycles for the access and the running 32-bit cycle
// total after it (wrapping). ROM window and backup costs come from the six
// wait-state registers, and reads of the keypad address cost nothing.
// Throughput is one item per clock while results are taken; an input register
// and a result register sit around the decode and single add. The slave side
// keeps accepting while a result waits, until both stages are full. The user must
// write configuration only while no item is in flight; the block does not check.
module bus_access_waitstate_timer
    import bwt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] bus_address, [33:32] access_width, zero fill to 40 bits
    input  logic [39:0] s_axis_tdata,
    // [1:0] access_kind, [2] is_read
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] wait_cycles, [9:6] region_code, [41:10] cycle_total, zero fill to 48
    output logic [47:0] m_axis_tdata
);

    rom_wait_t            rom_wait_reg;
    logic [ADDR_W-1:0]    keypad_reg;

    access_t              acc_reg;
    logic                 acc_valid_reg;
    logic                 out_valid_reg;
    logic [COST_W-1:0]    wait_reg;
    logic [REGION_W-1:0]  region_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;

    logic [COST_W-1:0]    wait_cycles;
    logic [REGION_W-1:0]  region_code;
    logic                 adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_wait_reg.first <= {WAIT_W'(4), WAIT_W'(4), WAIT_W'(4)};
            rom_wait_reg.next  <= {WAIT_W'(8), WAIT_W'(4), WAIT_W'(2)};
            keypad_reg         <= KEYPAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROM0_FIRST: rom_wait_reg.first[0] <= cfg_data[WAIT_W-1:0];
                CFG_ROM0_NEXT:  rom_wait_reg.next[0]  <= cfg_data[WAIT_W-1:0];
                CFG_ROM1_FIRST: rom_wait_reg.first[1] <= cfg_data[WAIT_W-1:0];
                CFG_ROM1_NEXT:  rom_wait_reg.next[1]  <= cfg_data[WAIT_W-1:0];
                CFG_ROM2_FIRST: rom_wait_reg.first[2] <= cfg_data[WAIT_W-1:0];
                CFG_ROM2_NEXT:  rom_wait_reg.next[2]  <= cfg_data[WAIT_W-1:0];
                CFG_KEYPAD:     keypad_reg            <= cfg_data;
                default: ;
            endcase
        end
    end

    // result stage moves when empty or being taken
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !acc_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_valid_reg <= 1'b0;
        else if (s_axis_tready)
            acc_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            acc_reg.bus_address  <= s_axis_tdata[31:0];
            acc_reg.access_width <= s_axis_tdata[33:32];
            acc_reg.access_kind  <= s_axis_tuser[1:0];
            acc_reg.is_read      <= s_axis_tuser[2];
        end
    end

    bwt_cost u_cost (
        .acc            (acc_reg),
        .rom_wait       (rom_wait_reg),
        .keypad_address (keypad_reg),
        .wait_cycles    (wait_cycles),
        .region_code    (region_code)
    );

    assign total_next = total_reg + TOTAL_W'(wait_cycles);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= acc_valid_reg;
            if (acc_valid_reg)
                total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && acc_valid_reg)
        begin
            wait_reg   <= wait_cycles;
            region_reg <= region_code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, total_reg, region_reg, wait_reg};

endmodule

### rtl/core/bwt_cost.sv
module bwt_cost
    import bwt_pkg::*;
(
    input  access_t             acc,
    input  rom_wait_t           rom_wait,
    input  logic [ADDR_W-1:0]   keypad_address,
    output logic [COST_W-1:0]   wait_cycles,
    output logic [REGION_W-1:0] region_code
);

    logic [7:0]          page;
    logic [7:0]          rom_off;
    logic [1:0]          win;
    region_t             region;
    logic [WAIT_W-1:0]   nfirst;
    logic [WAIT_W-1:0]   nnext;
    logic [WAIT_W-1:0]   first;
    logic [COST_W-1:0]   cost;
    logic                timed;

    assign page    = acc.bus_address[ADDR_W-1 -: 8];
    assign rom_off = page - PAGE_ROM_FIRST;

    always_comb
    begin
        if (page <= PAGE_LAST_ONCHIP)
            region = region_t'(page[REGION_W-1:0]);
        else if (page <= PAGE_ROM_LAST)
            region = region_t'(REGION_W'(REG_ROM0) + REGION_W'(rom_off[2:1]));
        else if (page == PAGE_BACKUP)
            region = REG_BACKUP;
        else
            region = REG_INVALID;
    end

    always_comb
    begin
        case (region)
            REG_ROM1: win = 2'd1;
            REG_ROM2: win = 2'd2;
            default:  win = 2'd0;
        endcase
    end

    assign nfirst = rom_wait.first[win];
    assign nnext  = rom_wait.next[win];
    assign first  = (acc.access_kind == KIND_SEQ) ? nnext : nfirst;

    always_comb
    begin
        case (region)
            REG_BIOS, REG_FAST_WRAM, REG_IO, REG_OAM:
                cost = COST_W'(1);
            REG_SLOW_WRAM:
                case (acc.access_width)
                    WIDTH_BYTE, WIDTH_HALF: cost = COST_W'(3);
                    WIDTH_WORD:             cost = COST_W'(6);
                    default:                cost = '0;
                endcase
            REG_PALETTE, REG_VRAM:
                case (acc.access_width)
                    WIDTH_BYTE, WIDTH_HALF: cost = COST_W'(1);
                    WIDTH_WORD:             cost = COST_W'(2);
                    default:                cost = '0;
                endcase
            REG_ROM0, REG_ROM1, REG_ROM2:
                case (acc.access_width)
                    WIDTH_BYTE, WIDTH_HALF: cost = COST_W'(first);
                    WIDTH_WORD:             cost = COST_W'(first) + COST_W'(nnext);
                    default:                cost = '0;
                endcase
            REG_BACKUP:
                cost = COST_W'(rom_wait.first[2]);
            default:
                cost = '0;
        endcase
    end

    // untimed kinds and keypad reads are free
    assign timed = (acc.access_kind == KIND_NONSEQ || acc.access_kind == KIND_SEQ)
                   && !(acc.is_read && acc.bus_address == keypad_address);

    assign wait_cycles = timed ? cost : '0;
    assign region_code = region;

endmodule
